FILE: src/lcdws_pkg.sv
// shared types, codes and constants for the character lcd write sequencer
`timescale 1ns / 1ps

package lcdws_pkg;

   // request codes
   localparam logic [1:0] CMD_INIT   = 2'd0;
   localparam logic [1:0] CMD_CHAR   = 2'd1;
   localparam logic [1:0] CMD_STRING = 2'd2;
   localparam logic [1:0] CMD_NUMBER = 2'd3;

   localparam logic [1:0] LINE_TOP    = 2'd1;
   localparam logic [1:0] LINE_BOTTOM = 2'd2;

   localparam logic [7:0] DDRAM_BASE = 8'h80;
   localparam logic [7:0] ROW_OFFSET = 8'h40;

   localparam logic [7:0] LCD_CLEAR        = 8'h01;
   localparam logic [7:0] LCD_FUNCTION_SET = 8'h38;
   localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;

   localparam logic       RS_COMMAND = 1'b0;
   localparam logic       RS_DATA    = 1'b1;

   // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
   localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
   localparam int          DIV10_SHIFT = 19;
   localparam logic [3:0]  ASCII_DIGIT_HI = 4'h3;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      JOB_INIT,
      JOB_CHAR,
      JOB_NUMBER
   } job_kind_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_READY
   } front_state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [1:0]  line;
      logic [4:0]  column;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic       reg_select;
      logic [7:0] bus_byte;
      logic       last;
   } rsp_type;

   // classified request as handed from the front to the back
   typedef struct packed {
      job_kind_type kind;
      logic         has_addr;
      logic [7:0]   addr_byte;
      logic [7:0]   char_byte;
      logic [19:0]  digits;     // most significant digit in [19:16]
   } job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   function automatic logic [7:0] init_byte(input logic [2:0] step);
      logic [7:0] b;
      case (step)
         3'd0:    b = LCD_CLEAR;
         3'd1:    b = LCD_FUNCTION_SET;
         3'd2:    b = LCD_DISPLAY_ON;
         3'd3:    b = LCD_ENTRY_MODE;
         default: b = LCD_ENTRY_MODE;
      endcase
      return b;
   endfunction

endpackage

FILE: src/lcdws_front.sv
// request intake: classification, address byte and decimal digit extraction
`timescale 1ns / 1ps

module lcdws_front
   import lcdws_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          push_job
);

   front_state_type state_ff, state_in;
   job_type         job_ff, job_in;
   logic [15:0]     quot_ff, quot_in;
   logic [1:0]      iter_ff, iter_in;

   logic            accept;
   logic [31:0]     prod;
   logic [12:0]     q;
   logic [15:0]     q_times10;
   logic [15:0]     rem;
   logic [7:0]      addr_base;
   logic            addr_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff  <= job_in;
      quot_ff <= quot_in;
      iter_ff <= iter_in;
   end

   always_comb begin
      prod      = {16'b0, quot_ff} * {16'b0, DIV10_MUL};
      q         = prod[31:DIV10_SHIFT];
      q_times10 = {q[12:0], 3'b0} + {2'b0, q[12:0], 1'b0};
      rem       = quot_ff - q_times10;

      addr_ok   = (req_data.line == LINE_TOP) || (req_data.line == LINE_BOTTOM);
      addr_base = (req_data.line == LINE_BOTTOM) ? (DDRAM_BASE + ROW_OFFSET) : DDRAM_BASE;

      busy   = (state_ff == FRONT_DIVIDE) || ((state_ff == FRONT_READY) && q_status.full);
      accept = start && !busy;
      push   = (state_ff == FRONT_READY) && !q_status.full;
      push_job = job_ff;

      state_in = state_ff;
      job_in   = job_ff;
      quot_in  = quot_ff;
      iter_in  = iter_ff;

      if (accept) begin
         job_in.addr_byte = addr_base + {3'b0, req_data.column} - 8'd1;
         job_in.char_byte = req_data.value[7:0];
         job_in.digits    = '0;
         quot_in          = req_data.value;
         iter_in          = '0;
         case (req_data.cmd)
            CMD_INIT: begin
               job_in.kind     = JOB_INIT;
               job_in.has_addr = 1'b0;
               state_in        = FRONT_READY;
            end
            CMD_CHAR: begin
               job_in.kind     = JOB_CHAR;
               job_in.has_addr = addr_ok;
               state_in        = FRONT_READY;
            end
            CMD_STRING: begin
               job_in.kind     = JOB_CHAR;
               job_in.has_addr = 1'b0;
               state_in        = FRONT_READY;
            end
            default: begin
               job_in.kind     = JOB_NUMBER;
               job_in.has_addr = addr_ok;
               state_in        = FRONT_DIVIDE;
            end
         endcase
      end else begin
         case (state_ff)
            FRONT_DIVIDE: begin
               // least significant digit first, shifted in from the top
               job_in.digits[15:0] = {rem[3:0], job_ff.digits[15:4]};
               quot_in             = {3'b0, q};
               iter_in             = iter_ff + 2'd1;
               if (iter_ff == 2'd3) begin
                  job_in.digits[19:16] = q[3:0];
                  state_in             = FRONT_READY;
               end
            end
            FRONT_READY: begin
               if (push) begin
                  state_in = FRONT_IDLE;
               end
            end
            default: begin
               state_in = FRONT_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: src/lcdws_queue.sv
// short job queue between the front and the back
`timescale 1ns / 1ps

module lcdws_queue
   import lcdws_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]       count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_comb begin
      status.full      = (count_ff == (PTR_W + 1)'(QUEUE_DEPTH));
      status.not_empty = (count_ff != '0);
      head_job         = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

endmodule

FILE: src/lcdws_back.sv
// write sequencer: steps through the bus writes of one job per request
`timescale 1ns / 1ps

module lcdws_back
   import lcdws_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          head_job,
   output logic             pop,
   output logic             rsp_strobe,
   output rsp_type          rsp_data
);

   logic       valid_ff, valid_in;
   job_type    job_ff, job_in;
   logic [2:0] step_ff, step_in;
   logic       strobe_ff;
   rsp_type    data_ff, data_in;

   logic       is_last;
   logic       finishing;
   logic [3:0] digit;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         strobe_ff <= valid_ff;
      end
      job_ff  <= job_in;
      step_ff <= step_in;
      data_ff <= data_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = data_ff;

   always_comb begin
      case (step_ff)
         3'd1:    digit = job_ff.digits[19:16];
         3'd2:    digit = job_ff.digits[15:12];
         3'd3:    digit = job_ff.digits[11:8];
         3'd4:    digit = job_ff.digits[7:4];
         default: digit = job_ff.digits[3:0];
      endcase

      data_in = '0;
      is_last = 1'b0;
      case (job_ff.kind)
         JOB_INIT: begin
            data_in.reg_select = RS_COMMAND;
            data_in.bus_byte   = init_byte(step_ff);
            is_last            = (step_ff == 3'd3);
         end
         JOB_CHAR: begin
            data_in.reg_select = (step_ff == 3'd0) ? RS_COMMAND : RS_DATA;
            data_in.bus_byte   = (step_ff == 3'd0) ? job_ff.addr_byte : job_ff.char_byte;
            is_last            = (step_ff == 3'd1);
         end
         default: begin
            data_in.reg_select = (step_ff == 3'd0) ? RS_COMMAND : RS_DATA;
            data_in.bus_byte   = (step_ff == 3'd0) ? job_ff.addr_byte : {ASCII_DIGIT_HI, digit};
            is_last            = (step_ff == 3'd5);
         end
      endcase
      data_in.last = is_last;

      finishing = valid_ff && is_last;
      pop       = q_status.not_empty && (!valid_ff || finishing);

      valid_in = valid_ff;
      job_in   = job_ff;
      step_in  = step_ff;
      if (pop) begin
         valid_in = 1'b1;
         job_in   = head_job;
         // no address write: start at the first data write
         step_in  = ((head_job.kind != JOB_INIT) && !head_job.has_addr) ? 3'd1 : 3'd0;
      end else if (finishing) begin
         valid_in = 1'b0;
      end else if (valid_ff) begin
         step_in = step_ff + 3'd1;
      end
   end

endmodule

FILE: src/char_lcd_write_sequencer.sv
// top level: front intake, job queue and bus write sequencer
// path: front job register, queue (waits while the sequencer is busy), sequencer job
//   register, output register; a number request first takes four divide-by-ten steps
// throughput: the sequencer gives one bus write per cycle while it holds a job, 1 to 6
//   writes per request; front takes one request per cycle unless dividing or queue full
// reset: synchronous, clears front state, queue and sequencer; receiver cannot stall
`timescale 1ns / 1ps

module char_lcd_write_sequencer
   import lcdws_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          head_job;
   queue_status_type q_status;

   lcdws_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   lcdws_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   lcdws_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // writes of one request come out on consecutive cycles
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe)
      else $error("write run broken before its last write");

   // a number request keeps the front busy while its digits are worked out
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.cmd == CMD_NUMBER) |=> busy)
      else $error("front free during digit extraction");

   // never push into a full queue, unless a pop frees an entry alongside it
   assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push || pop)
      else $error("push into full job queue");

   assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe after reset");

endmodule

FILE: sim/tb.sv
// self-checking testbench for the character lcd write sequencer
`timescale 1ns / 1ps

module tb;
   import lcdws_pkg::*;

   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam int MAX_WRITES = 6;
   localparam int RANDOM_REQUESTS = 430;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   rsp_type writes_due[$];
   int      fail_count = 0;
   bit      back_to_back = 1'b0;

   char_lcd_write_sequencer u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #10 clock = ~clock;

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function automatic req_type make_req(input logic [1:0] cmd, input logic [1:0] line,
                                        input logic [4:0] column, input logic [15:0] value);
      req_type r;
      r.cmd    = cmd;
      r.line   = line;
      r.column = column;
      r.value  = value;
      return r;
   endfunction

   // expected bus writes for one request, appended in order
   function automatic void queue_bus_writes(input req_type r);
      rsp_type    w[MAX_WRITES];
      int         n;
      logic [7:0] base;
      logic [7:0] addr;
      logic [15:0] v;
      bit         has_addr;
      n = 0;
      v = r.value;
      has_addr = 1'b1;
      if (r.line == LINE_TOP) begin
         base = DDRAM_BASE;
      end else if (r.line == LINE_BOTTOM) begin
         base = DDRAM_BASE + ROW_OFFSET;
      end else begin
         base = '0;
         has_addr = 1'b0;
      end
      // column is not range checked, so column 0 wraps below the row base
      addr = base + {3'b000, r.column} - 8'd1;
      case (r.cmd)
         CMD_INIT: begin
            w[0] = '{RS_COMMAND, LCD_CLEAR, 1'b0};
            w[1] = '{RS_COMMAND, LCD_FUNCTION_SET, 1'b0};
            w[2] = '{RS_COMMAND, LCD_DISPLAY_ON, 1'b0};
            w[3] = '{RS_COMMAND, LCD_ENTRY_MODE, 1'b0};
            n = 4;
         end
         CMD_CHAR: begin
            if (has_addr) begin
               w[n] = '{RS_COMMAND, addr, 1'b0};
               n++;
            end
            w[n] = '{RS_DATA, v[7:0], 1'b0};
            n++;
         end
         CMD_STRING: begin
            w[0] = '{RS_DATA, v[7:0], 1'b0};
            n = 1;
         end
         default: begin
            if (has_addr) begin
               w[n] = '{RS_COMMAND, addr, 1'b0};
               n++;
            end
            w[n]     = '{RS_DATA, ASCII_ZERO + 8'(v / 16'd10000), 1'b0};
            w[n + 1] = '{RS_DATA, ASCII_ZERO + 8'((v % 16'd10000) / 16'd1000), 1'b0};
            w[n + 2] = '{RS_DATA, ASCII_ZERO + 8'((v % 16'd1000) / 16'd100), 1'b0};
            w[n + 3] = '{RS_DATA, ASCII_ZERO + 8'((v % 16'd100) / 16'd10), 1'b0};
            w[n + 4] = '{RS_DATA, ASCII_ZERO + 8'(v % 16'd10), 1'b0};
            n += 5;
         end
      endcase
      w[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) begin
         writes_due.push_back(w[i]);
      end
   endfunction

   // entered and left on a falling edge; start stays high across back-to-back requests
   task automatic send_request(input req_type item);
      int gap;
      gap = back_to_back ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      queue_bus_writes(item);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (writes_due.size() == 0) begin
            note_failure($sformatf("unexpected write rs=%0b byte=%02h last=%0b",
                                   rsp_data.reg_select, rsp_data.bus_byte, rsp_data.last));
         end else begin
            want = writes_due.pop_front();
            if (rsp_data.reg_select !== want.reg_select || rsp_data.bus_byte !== want.bus_byte
                || rsp_data.last !== want.last) begin
               note_failure($sformatf(
                  "write mismatch: expected rs=%0b byte=%02h last=%0b, got rs=%0b byte=%02h last=%0b",
                  want.reg_select, want.bus_byte, want.last,
                  rsp_data.reg_select, rsp_data.bus_byte, rsp_data.last));
            end
         end
      end
   end

   task automatic test_init;
      send_request(make_req(CMD_INIT, 2'd0, 5'd0, 16'h0000));
      send_request(make_req(CMD_INIT, 2'd3, 5'd31, 16'hFFFF));
   endtask

   task automatic test_char_at_position;
      send_request(make_req(CMD_CHAR, LINE_TOP, 5'd1, 16'h0041));
      send_request(make_req(CMD_CHAR, LINE_TOP, 5'd16, 16'h00FF));
      send_request(make_req(CMD_CHAR, LINE_BOTTOM, 5'd1, 16'h0000));
      send_request(make_req(CMD_CHAR, LINE_BOTTOM, 5'd16, 16'h1234));
      // column zero wraps below the row base
      send_request(make_req(CMD_CHAR, LINE_TOP, 5'd0, 16'hFF5A));
      send_request(make_req(CMD_CHAR, LINE_BOTTOM, 5'd0, 16'h00A5));
      send_request(make_req(CMD_CHAR, LINE_BOTTOM, 5'd31, 16'h8001));
      // bad line: data write only
      send_request(make_req(CMD_CHAR, 2'd0, 5'd5, 16'h0030));
      send_request(make_req(CMD_CHAR, 2'd3, 5'd7, 16'h7F7F));
   endtask

   task automatic test_string_chars;
      send_request(make_req(CMD_STRING, LINE_TOP, 5'd3, 16'h0000));
      send_request(make_req(CMD_STRING, 2'd3, 5'd31, 16'hFFFF));
      send_request(make_req(CMD_STRING, 2'd0, 5'd0, 16'hA55A));
   endtask

   task automatic test_number;
      send_request(make_req(CMD_NUMBER, LINE_TOP, 5'd1, 16'd0));
      send_request(make_req(CMD_NUMBER, LINE_BOTTOM, 5'd16, 16'd65535));
      send_request(make_req(CMD_NUMBER, LINE_TOP, 5'd5, 16'd10000));
      send_request(make_req(CMD_NUMBER, LINE_BOTTOM, 5'd0, 16'd9));
      send_request(make_req(CMD_NUMBER, 2'd0, 5'd3, 16'd12345));
      send_request(make_req(CMD_NUMBER, 2'd3, 5'd31, 16'd59999));
      send_request(make_req(CMD_NUMBER, LINE_TOP, 5'd10, 16'd99));
   endtask

   task automatic test_random_requests;
      logic [1:0]  cmd;
      logic [1:0]  line;
      logic [4:0]  column;
      logic [15:0] value;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         // alternate stretches of back-to-back requests with gappy ones
         if (i % 40 == 0) begin
            back_to_back = ($urandom_range(0, 2) == 0);
         end
         cmd = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 9) < 8) begin
            line = ($urandom_range(0, 1) == 0) ? LINE_TOP : LINE_BOTTOM;
         end else begin
            line = 2'($urandom_range(0, 3));
         end
         if ($urandom_range(0, 99) < 85) begin
            column = 5'($urandom_range(1, 16));
         end else begin
            column = 5'($urandom_range(0, 31));
         end
         case ($urandom_range(0, 9))
            0:       value = 16'd65535 - 16'($urandom_range(0, 15));
            1:       value = 16'($urandom_range(0, 15));
            default: value = 16'($urandom);
         endcase
         send_request(make_req(cmd, line, column, value));
      end
      back_to_back = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_init;
      test_char_at_position;
      test_string_chars;
      test_number;
      test_random_requests;
      start <= 1'b0;
      while (writes_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && writes_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
